// File: rtl/hatpm_pkg.sv
package hatpm_pkg;

   // HID usage page and usage codes
   localparam logic [15:0] PAGE_DESKTOP  = 16'h0001;
   localparam logic [15:0] USAGE_FORWARD = 16'h0031;
   localparam logic [15:0] USAGE_TURN    = 16'h0033;
   localparam logic [15:0] USAGE_SHOOT   = 16'h0093;

   // configuration register indexes
   localparam logic [7:0] CSR_DEADZONE = 8'd0;
   localparam logic [7:0] CSR_PWM      = 8'd1;

   localparam logic [15:0] DEADZONE_RESET = 16'd6554;
   localparam logic [14:0] PWM_RESET      = 15'd255;

   // Q1.16 full deflection
   localparam logic [16:0] Q16_ONE = 17'h10000;

   // what a field does to the packet
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_NONE  = 2'd0;
   localparam kind_type KIND_FWD   = 2'd1;
   localparam kind_type KIND_TURN  = 2'd2;
   localparam kind_type KIND_SHOOT = 2'd3;

   // control that travels with an item down the pipeline
   typedef struct packed {
      kind_type kind;
      logic     neg;
      logic     zero;
      logic     press;
   } tag_type;

   // one entry of the queue between front and back
   typedef struct packed {
      kind_type    kind;
      logic [15:0] drive;
      logic        press;
   } entry_type;

endpackage

// File: rtl/hatpm_front.sv
module hatpm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [15:0]              req_usage_page,
   input  logic [15:0]              req_usage_code,
   input  logic signed [16:0]       req_field_value,
   input  logic signed [16:0]       req_range_min,
   input  logic signed [16:0]       req_range_max,
   input  logic [15:0]              deadzone,
   input  logic [14:0]              pwm_scale,
   output logic                     push_valid,
   input  logic                     push_ready,
   output hatpm_pkg::entry_type     push_entry
);
   import hatpm_pkg::*;

   localparam int NSTEPS = 17;
   localparam int DSTEPS = 15;

   logic adv;

   // normalize divider stages; index 0 holds the decoded beat
   logic              n_vld_ff [0:NSTEPS];
   tag_type           n_tag_ff [0:NSTEPS];
   logic              n_sat_ff [0:NSTEPS];
   logic [18:0]       n_rem_ff [0:NSTEPS];
   logic [17:0]       n_den_ff [0:NSTEPS];
   logic [16:0]       n_q_ff   [0:NSTEPS];

   // clamp and deadzone stage
   logic              c_vld_ff;
   tag_type           c_tag_ff;
   logic [16:0]       c_diff_ff;
   logic [16:0]       c_dv_ff;

   // scale divider stages; index 0 holds the product
   logic              d_vld_ff  [0:DSTEPS];
   tag_type           d_tag_ff  [0:DSTEPS];
   logic [16:0]       d_rem_ff  [0:DSTEPS];
   logic [14:0]       d_low_ff  [0:DSTEPS];
   logic [16:0]       d_dv_ff   [0:DSTEPS];
   logic [14:0]       d_q_ff    [0:DSTEPS];

   // stall everything only when the last stage cannot leave
   assign adv       = !d_vld_ff[DSTEPS] || push_ready;
   assign req_ready = adv;

   // decode the beat and form numerator and range
   logic signed [19:0] num_in;
   logic signed [18:0] span_in;
   tag_type            tag_in;
   logic [18:0]        mag_in;

   always_comb begin
      num_in  = 20'(req_field_value) + 20'(req_field_value)
              - 20'(req_range_min) - 20'(req_range_max);
      span_in = 19'(req_range_max) - 19'(req_range_min);
      mag_in  = num_in[19] ? 19'(-num_in) : num_in[18:0];
      tag_in.kind = KIND_NONE;
      if (req_usage_page == PAGE_DESKTOP) begin
         if (req_usage_code == USAGE_FORWARD) tag_in.kind = KIND_FWD;
         else if (req_usage_code == USAGE_TURN) tag_in.kind = KIND_TURN;
         else if (req_usage_code == USAGE_SHOOT) tag_in.kind = KIND_SHOOT;
      end
      tag_in.neg   = num_in[19];
      tag_in.zero  = span_in[18] || (span_in == '0);
      tag_in.press = (req_field_value != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         n_vld_ff[0] <= req_valid;
      end
      if (adv) begin
         n_tag_ff[0] <= tag_in;
         n_sat_ff[0] <= 1'b0;
         n_rem_ff[0] <= mag_in;
         n_den_ff[0] <= span_in[17:0];
         n_q_ff[0]   <= '0;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < NSTEPS; k++) begin : g_norm
      logic [18:0] trial;
      logic        take;
      always_comb begin
         trial = (k == 0) ? n_rem_ff[k] : {n_rem_ff[k][17:0], 1'b0};
         take  = (trial >= 19'(n_den_ff[k]));
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            n_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            n_vld_ff[k+1] <= n_vld_ff[k];
         end
         if (adv) begin
            n_tag_ff[k+1] <= n_tag_ff[k];
            n_den_ff[k+1] <= n_den_ff[k];
            if (k == 0) begin
               n_sat_ff[k+1] <= (n_rem_ff[k] >= {n_den_ff[k], 1'b0});
            end else begin
               n_sat_ff[k+1] <= n_sat_ff[k];
            end
            n_rem_ff[k+1] <= take ? (trial - 19'(n_den_ff[k])) : trial;
            n_q_ff[k+1]   <= n_q_ff[k] | (take ? (17'd1 << (NSTEPS - 1 - k)) : 17'd0);
         end
      end
   end

   // clamp to full deflection and apply the deadzone
   logic [16:0] magn;
   tag_type     c_tag_in;
   always_comb begin
      magn = (n_sat_ff[NSTEPS] || n_q_ff[NSTEPS] > Q16_ONE) ? Q16_ONE : n_q_ff[NSTEPS];
      c_tag_in = n_tag_ff[NSTEPS];
      c_tag_in.zero = n_tag_ff[NSTEPS].zero || (magn < 17'(deadzone));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= n_vld_ff[NSTEPS];
      end
      if (adv) begin
         c_tag_ff  <= c_tag_in;
         c_diff_ff <= magn - 17'(deadzone);
         c_dv_ff   <= Q16_ONE - 17'(deadzone);
      end
   end

   // scale by the full-scale drive
   logic [31:0] prod;
   assign prod = 32'(c_diff_ff) * 32'(pwm_scale);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         d_vld_ff[0] <= c_vld_ff;
      end
      if (adv) begin
         d_tag_ff[0] <= c_tag_ff;
         d_rem_ff[0] <= prod[31:15];
         d_low_ff[0] <= prod[14:0];
         d_dv_ff[0]  <= c_dv_ff;
         d_q_ff[0]   <= '0;
      end
   end

   // divide by the span above the deadzone, one bit per stage
   for (genvar k = 0; k < DSTEPS; k++) begin : g_scale
      logic [17:0] trial;
      logic        take;
      always_comb begin
         trial = {d_rem_ff[k], d_low_ff[k][DSTEPS-1-k]};
         take  = (trial >= 18'(d_dv_ff[k]));
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            d_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            d_vld_ff[k+1] <= d_vld_ff[k];
         end
         if (adv) begin
            d_tag_ff[k+1] <= d_tag_ff[k];
            d_low_ff[k+1] <= d_low_ff[k];
            d_dv_ff[k+1]  <= d_dv_ff[k];
            d_rem_ff[k+1] <= take ? 17'(trial - 18'(d_dv_ff[k])) : trial[16:0];
            d_q_ff[k+1]   <= d_q_ff[k] | (take ? (15'd1 << (DSTEPS - 1 - k)) : 15'd0);
         end
      end
   end

   // restore the sign and hand the beat to the queue
   logic [15:0] mag_out;
   always_comb begin
      mag_out          = d_tag_ff[DSTEPS].zero ? 16'd0 : {1'b0, d_q_ff[DSTEPS]};
      push_valid       = d_vld_ff[DSTEPS];
      push_entry.kind  = d_tag_ff[DSTEPS].kind;
      push_entry.press = d_tag_ff[DSTEPS].press;
      push_entry.drive = d_tag_ff[DSTEPS].neg ? 16'(-mag_out) : mag_out;
   end

endmodule

// File: rtl/hatpm_fifo.sv
module hatpm_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  hatpm_pkg::entry_type push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output hatpm_pkg::entry_type pop_entry
);
   import hatpm_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   entry_type        mem_ff [0:DEPTH-1];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != (AW+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and track fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // store the beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/hatpm_back.sv
module hatpm_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  hatpm_pkg::entry_type pop_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [15:0]   rsp_forward_drive,
   output logic signed [15:0]   rsp_turn_drive,
   output logic                 rsp_shoot,
   output logic                 rsp_field_used
);
   import hatpm_pkg::*;

   logic [15:0] fwd_ff, fwd_in;
   logic [15:0] turn_ff, turn_in;
   logic        shoot_ff, shoot_in;
   logic        used_in;
   logic        rsp_valid_ff;
   logic [15:0] rsp_fwd_ff, rsp_turn_ff;
   logic        rsp_shoot_ff, rsp_used_ff;
   logic        take;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;

   // apply the entry to the held packet
   always_comb begin
      fwd_in   = fwd_ff;
      turn_in  = turn_ff;
      shoot_in = shoot_ff;
      used_in  = 1'b1;
      unique case (pop_entry.kind)
         KIND_FWD:   fwd_in   = pop_entry.drive;
         KIND_TURN:  turn_in  = pop_entry.drive;
         KIND_SHOOT: shoot_in = pop_entry.press;
         default:    used_in  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff       <= '0;
         turn_ff      <= '0;
         shoot_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            fwd_ff   <= fwd_in;
            turn_ff  <= turn_in;
            shoot_ff <= shoot_in;
         end
         if (pop_ready) begin
            rsp_valid_ff <= pop_valid;
         end
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_fwd_ff   <= fwd_in;
         rsp_turn_ff  <= turn_in;
         rsp_shoot_ff <= shoot_in;
         rsp_used_ff  <= used_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_forward_drive = rsp_fwd_ff;
   assign rsp_turn_drive    = rsp_turn_ff;
   assign rsp_shoot         = rsp_shoot_ff;
   assign rsp_field_used    = rsp_used_ff;

endmodule

// File: rtl/hid_axis_to_pwm_mapper.sv
// HID report field to drive packet mapper.
// req_ channel: one HID field per beat (page, usage, value, logical range).
// rsp_ channel: one beat per request with the held forward and turn drive,
//    the shoot bit and whether this field's usage is mapped into the packet.
// csr_ channel: index 0 deadzone (Q0.16), index 1 full-scale drive; always
//    ready, other indexes ignored. Write only while no request is in flight.
// Throughput: one field per cycle unless the receiver stalls. The normalize divide
//    (17 stages, one quotient bit each) and the scale divide (15 stages) are
//    fully pipelined.
// Reset clears the held packet to zero, restores the register defaults and
//    empties the pipeline and queue.
// When the receiver stalls, the response register holds, the queue between
//    the pipeline and the packet logic fills, and then the whole pipeline
//    freezes and req_ready drops in the same cycle.
module hid_axis_to_pwm_mapper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_usage_page,
   input  logic [15:0]        req_usage_code,
   input  logic signed [16:0] req_field_value,
   input  logic signed [16:0] req_range_min,
   input  logic signed [16:0] req_range_max,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_forward_drive,
   output logic signed [15:0] rsp_turn_drive,
   output logic               rsp_shoot,
   output logic               rsp_field_used,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import hatpm_pkg::*;

   logic [15:0] deadzone_ff;
   logic [14:0] pwm_ff;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= DEADZONE_RESET;
         pwm_ff      <= PWM_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_DEADZONE) deadzone_ff <= csr_wdata;
         else if (csr_index == CSR_PWM) pwm_ff <= csr_wdata[14:0];
      end
   end

   logic      push_valid, push_ready, pop_valid, pop_ready;
   entry_type push_entry, pop_entry;

   hatpm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_usage_page  (req_usage_page),
      .req_usage_code  (req_usage_code),
      .req_field_value (req_field_value),
      .req_range_min   (req_range_min),
      .req_range_max   (req_range_max),
      .deadzone        (deadzone_ff),
      .pwm_scale       (pwm_ff),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_entry      (push_entry)
   );

   hatpm_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   hatpm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_forward_drive (rsp_forward_drive),
      .rsp_turn_drive    (rsp_turn_drive),
      .rsp_shoot         (rsp_shoot),
      .rsp_field_used    (rsp_field_used)
   );

endmodule
